// ----- rtl/biq_pkg.sv -----
// Shared widths, types, register indexes and saturation helpers for the biquad filter.
`timescale 1ns / 1ps
`default_nettype none

package biq_pkg;

  // Field and state formats
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int STATE_W  = 40;
  localparam int FRAC_W   = 22;

  // Coefficient digits, one consumed per multiply step
  localparam int DIGIT_W  = 8;
  localparam int DIGITS   = COEF_W / DIGIT_W;
  localparam int CNT_W    = $clog2(DIGITS);

  // Accumulator for coefficient times state-format value
  localparam int MAC_W    = COEF_W + STATE_W;
  // Headroom for the delay update sums before saturation
  localparam int WIDE_W   = STATE_W + 4;
  // Feedback term after dropping the fraction bits
  localparam int FB_W     = MAC_W - FRAC_W;
  // Output after rounding, before clamping to the sample range
  localparam int QUOT_W   = STATE_W + 1 - FRAC_W;

  localparam int CFG_IDX_W = 3;
  localparam int COEFS     = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic signed [MAC_W-1:0]    mac_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;
  typedef logic signed [FB_W-1:0]     fb_t;
  typedef logic signed [QUOT_W-1:0]   quot_t;
  typedef logic signed [DIGIT_W:0]    digit_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_B0 = cfg_idx_t'(0);
  localparam cfg_idx_t REG_B1 = cfg_idx_t'(1);
  localparam cfg_idx_t REG_B2 = cfg_idx_t'(2);
  localparam cfg_idx_t REG_A1 = cfg_idx_t'(3);
  localparam cfg_idx_t REG_A2 = cfg_idx_t'(4);

  // Unity gain in Q2.22
  localparam coef_t COEF_ONE = coef_t'(1) <<< FRAC_W;

  localparam cnt_t LAST_DIGIT = cnt_t'(DIGITS - 1);

  localparam state_t STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam state_t STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Half an LSB of the integer part, for round half up
  localparam mac_t ROUND_MAC = mac_t'(1) <<< (FRAC_W - 1);
  localparam logic signed [STATE_W:0] ROUND_Y = (STATE_W+1)'(1) <<< (FRAC_W - 1);

  // Clamp a wide sum to the signed state range
  function automatic state_t sat_state(input wide_t v);
    if (v[WIDE_W-1:STATE_W-1] == {(WIDE_W-STATE_W+1){v[STATE_W-1]}}) begin
      return v[STATE_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return STATE_MIN;
    end else begin
      return STATE_MAX;
    end
  endfunction

  // Clamp a rounded value to the signed sample range
  function automatic sample_t sat_sample(input quot_t v);
    if (v[QUOT_W-1:SAMPLE_W-1] == {(QUOT_W-SAMPLE_W+1){v[SAMPLE_W-1]}}) begin
      return v[SAMPLE_W-1:0];
    end else if (v[QUOT_W-1]) begin
      return SAMPLE_MIN;
    end else begin
      return SAMPLE_MAX;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/biq_ifs.sv -----
// Channel interfaces of the biquad filter: input samples, filtered samples, coefficient writes.
`timescale 1ns / 1ps
`default_nettype none

interface biq_sample_if;
  import biq_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_result_if;
  import biq_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface biq_cfg_if;
  import biq_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  coef_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/biquad_iir_filter_unit.sv -----
// Biquad IIR section, transposed direct form II, with digit-serial coefficient multipliers.
// Each sample passes through three digit steps on x, the forming of y, three digit steps
//   on y and the delay update, which waits while the previous result is still unclaimed.
// A new sample is taken only once the last one is through, since the 8-bit-digit serial
//   multipliers walk the 24-bit coefficients, first against x and then against y.
// Reset (rst, synchronous): b0 = 1.0, other coefficients and both delays zero, no result held.
`timescale 1ns / 1ps
`default_nettype none

module biquad_iir_filter_unit (
  input wire         clk,
  input wire         rst,
  biq_sample_if.sink samples,
  biq_result_if.source filtered,
  biq_cfg_if.sink    cfg
);
  import biq_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MULX   = 3'd1;
  localparam logic [2:0] ST_SUMY   = 3'd2;
  localparam logic [2:0] ST_MULY   = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;

  logic [2:0] state;
  cnt_t       cnt;

  coef_t   coef [COEFS];
  state_t  delay_one;
  state_t  delay_two;

  sample_t x_reg;
  state_t  y;
  coef_t   cx [3];
  coef_t   cy [2];
  state_t  acc_x [3];
  mac_t    acc_y [2];

  logic    out_valid;
  sample_t out_sample;

  logic    first;
  logic    last;
  digit_t  dig_x [3];
  digit_t  dig_y [2];
  logic signed [SAMPLE_W+DIGIT_W:0] prod_x [3];
  logic signed [STATE_W+DIGIT_W:0]  prod_y [2];
  state_t  acc_x_next [3];
  mac_t    acc_y_next [2];

  fb_t     fb_one;
  fb_t     fb_two;
  wide_t   y_sum;
  wide_t   n1_sum;
  wide_t   n2_sum;
  logic signed [STATE_W:0] y_round;
  quot_t   y_quot;

  assign samples.ready   = (state == ST_IDLE);
  assign cfg.ready       = 1'b1;
  assign filtered.valid  = out_valid;
  assign filtered.sample_out = out_sample;

  assign first = (cnt == '0);
  assign last  = (cnt == LAST_DIGIT);

  // One coefficient digit times the multiplicand; top digit carries the sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dig_x[i] = first ? {cx[i][COEF_W-1], cx[i][COEF_W-1 -: DIGIT_W]}
                       : {1'b0, cx[i][COEF_W-1 -: DIGIT_W]};
      prod_x[i] = x_reg * dig_x[i];
      acc_x_next[i] = (first ? state_t'(0) : (acc_x[i] <<< DIGIT_W)) + state_t'(prod_x[i]);
    end
    for (int j = 0; j < 2; j++) begin
      dig_y[j] = first ? {cy[j][COEF_W-1], cy[j][COEF_W-1 -: DIGIT_W]}
                       : {1'b0, cy[j][COEF_W-1 -: DIGIT_W]};
      prod_y[j] = y * dig_y[j];
      // Fold in the rounding half on the last digit
      acc_y_next[j] = (first ? mac_t'(0) : (acc_y[j] <<< DIGIT_W)) + mac_t'(prod_y[j])
                      + (last ? ROUND_MAC : mac_t'(0));
    end
  end

  // Form y, the new delays and the rounded output
  always_comb begin
    y_sum   = wide_t'(acc_x[0]) + wide_t'(delay_one);
    fb_one  = acc_y[0][MAC_W-1:FRAC_W];
    fb_two  = acc_y[1][MAC_W-1:FRAC_W];
    n1_sum  = wide_t'(acc_x[1]) - wide_t'(fb_one) + wide_t'(delay_two);
    n2_sum  = wide_t'(acc_x[2]) - wide_t'(fb_two);
    y_round = (STATE_W+1)'(y) + ROUND_Y;
    y_quot  = y_round[STATE_W:FRAC_W];
  end

  // Hold coefficients; take writes on known indexes, drop the rest
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[REG_B0] <= COEF_ONE;
      coef[REG_B1] <= '0;
      coef[REG_B2] <= '0;
      coef[REG_A1] <= '0;
      coef[REG_A2] <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_B0:  coef[REG_B0] <= cfg.data;
        REG_B1:  coef[REG_B1] <= cfg.data;
        REG_B2:  coef[REG_B2] <= cfg.data;
        REG_A1:  coef[REG_A1] <= cfg.data;
        REG_A2:  coef[REG_A2] <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sequence one sample through both multiply passes and the delay update
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      delay_one <= '0;
      delay_two <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop a claimed result; the update step refills the register itself
      if (filtered.valid && filtered.ready && state != ST_UPDATE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            x_reg <= samples.sample_in;
            cx[0] <= coef[REG_B0];
            cx[1] <= coef[REG_B1];
            cx[2] <= coef[REG_B2];
            cy[0] <= coef[REG_A1];
            cy[1] <= coef[REG_A2];
            cnt   <= '0;
            state <= ST_MULX;
          end
        end
        ST_MULX: begin
          for (int i = 0; i < 3; i++) begin
            acc_x[i] <= acc_x_next[i];
            cx[i]    <= cx[i] << DIGIT_W;
          end
          if (last) begin
            cnt   <= '0;
            state <= ST_SUMY;
          end else begin
            cnt <= cnt + cnt_t'(1);
          end
        end
        ST_SUMY: begin
          y     <= sat_state(y_sum);
          state <= ST_MULY;
        end
        ST_MULY: begin
          for (int j = 0; j < 2; j++) begin
            acc_y[j] <= acc_y_next[j];
            cy[j]    <= cy[j] << DIGIT_W;
          end
          if (last) begin
            cnt   <= '0;
            state <= ST_UPDATE;
          end else begin
            cnt <= cnt + cnt_t'(1);
          end
        end
        ST_UPDATE: begin
          // Wait here while the previous result is still unclaimed
          if (!out_valid || filtered.ready) begin
            delay_one  <= sat_state(n1_sum);
            delay_two  <= sat_state(n2_sum);
            out_sample <= sat_sample(y_quot);
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> state == ST_MULX && cnt == '0)
    else $error("accepted sample did not start the first multiply pass");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_UPDATE)
    else $error("result appeared without a delay update");

  a_digit_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULX || state == ST_MULY) |-> cnt <= LAST_DIGIT)
    else $error("digit counter ran past the last coefficient digit");

endmodule

`default_nettype wire
